// File: rtl/mjli_pkg.sv
`default_nettype none

package mjli_pkg;

    localparam int IN_JOINTS = 6;
    localparam int JOINT_W   = 3;
    localparam int ANGLE_W   = 8;
    localparam int DUR_W     = 16;
    localparam int STEP_W    = $clog2(ANGLE_W);

    localparam logic OP_MOVE     = 1'b0;
    localparam logic OP_TICK     = 1'b1;
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

    typedef logic [ANGLE_W-1:0] angle_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CALC,
        ST_EMIT,
        ST_STEP
    } seq_state_t;

    typedef enum logic [1:0] {
        AR_IDLE,
        AR_MUL,
        AR_DIV
    } arith_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } arith_status_t;

    function automatic angle_t home_angle(input int j);
        angle_t a;
        unique case (j)
            0, 1:    a = 8'd180;
            2, 3:    a = 8'd90;
            default: a = 8'd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// File: rtl/mjli_arith.sv
`default_nettype none

module mjli_arith #(
    parameter int TIME_BITS = 16
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        start,
    input  wire mjli_pkg::angle_t      angle_start,
    input  wire mjli_pkg::angle_t      angle_goal,
    input  wire [TIME_BITS-1:0]        duration,
    input  wire [TIME_BITS-1:0]        elapsed,
    output mjli_pkg::angle_t           quotient,
    output mjli_pkg::arith_status_t    status
);
    import mjli_pkg::*;

    localparam int AW = TIME_BITS + ANGLE_W;

    arith_state_t          state_reg, state_next;
    logic [STEP_W-1:0]     cnt_reg;
    logic                  done_reg;
    angle_t                a_reg, g_reg;
    logic [TIME_BITS-1:0]  dme_reg;
    logic [AW-1:0]         acc_reg;

    logic [TIME_BITS-1:0]  addend;
    logic [TIME_BITS:0]    trial;
    logic [TIME_BITS:0]    diff;
    logic                  qbit;

    // shift-add: num = a*(D-e) + g*e, one bit of a and g per cycle
    always_comb
    begin
        if (a_reg[ANGLE_W-1] && g_reg[ANGLE_W-1])
            addend = duration;
        else if (a_reg[ANGLE_W-1])
            addend = dme_reg;
        else if (g_reg[ANGLE_W-1])
            addend = elapsed;
        else
            addend = '0;
    end

    // restoring divide, one quotient bit per cycle; remainder stays below D
    assign trial = {acc_reg[AW-1:ANGLE_W], acc_reg[ANGLE_W-1]};
    assign diff  = trial - {1'b0, duration};
    assign qbit  = (trial >= {1'b0, duration});

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            AR_IDLE:
            begin
                if (start)
                    state_next = AR_MUL;
            end
            AR_MUL:
            begin
                if (cnt_reg == STEP_W'(ANGLE_W - 1))
                    state_next = AR_DIV;
            end
            AR_DIV:
            begin
                if (cnt_reg == STEP_W'(ANGLE_W - 1))
                    state_next = AR_IDLE;
            end
            default: state_next = AR_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= AR_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == AR_DIV) && (cnt_reg == STEP_W'(ANGLE_W - 1));
            if (state_reg == AR_IDLE)
                cnt_reg <= '0;
            else
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            AR_IDLE:
            begin
                if (start)
                begin
                    a_reg   <= angle_start;
                    g_reg   <= angle_goal;
                    dme_reg <= duration - elapsed;
                    acc_reg <= '0;
                end
            end
            AR_MUL:
            begin
                acc_reg <= (acc_reg << 1) + AW'(addend);
                a_reg   <= a_reg << 1;
                g_reg   <= g_reg << 1;
            end
            AR_DIV:
            begin
                if (qbit)
                    acc_reg <= {diff[TIME_BITS-1:0], acc_reg[ANGLE_W-2:0], 1'b1};
                else
                    acc_reg <= {trial[TIME_BITS-1:0], acc_reg[ANGLE_W-2:0], 1'b0};
            end
            default: ;
        endcase
    end

    assign quotient    = acc_reg[ANGLE_W-1:0];
    assign status.busy = (state_reg != AR_IDLE);
    assign status.done = done_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == AR_IDLE)
        else $error("arith start while running");

    a_done_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == AR_DIV) && state_reg == AR_IDLE)
        else $error("arith done without divide pass");

endmodule

`default_nettype wire

// File: rtl/multi_joint_linear_move_interpolator.sv
`default_nettype none

// Linear move interpolator for up to six joints. A move command (operation 0)
// is answered with a single reject result if a move is running. A tick
// (operation 1) during a move produces one angle write per masked joint, in
// joint order, with last set on the final one. Each write comes from one
// shared bit-serial unit: shift-add for the weighted sum, then restoring
// division by the duration; a tick lasts longer the more joints move, and
// longer if the output side stalls.
module multi_joint_linear_move_interpolator #(
    parameter int JOINT_COUNT = 6,
    parameter int TIME_BITS   = 16
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire                          operation,
    input  wire [5:0]                    joint_mask,
    input  wire mjli_pkg::angle_t        target_0,
    input  wire mjli_pkg::angle_t        target_1,
    input  wire mjli_pkg::angle_t        target_2,
    input  wire mjli_pkg::angle_t        target_3,
    input  wire mjli_pkg::angle_t        target_4,
    input  wire mjli_pkg::angle_t        target_5,
    input  wire [mjli_pkg::DUR_W-1:0]    move_time_ms,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic                         kind,
    output logic [mjli_pkg::JOINT_W-1:0] joint,
    output mjli_pkg::angle_t             angle,
    output logic                         last
);
    import mjli_pkg::*;

    localparam int ACTIVE_JOINTS = (JOINT_COUNT < IN_JOINTS) ? JOINT_COUNT : IN_JOINTS;
    localparam logic [IN_JOINTS-1:0] ACTIVE_MASK = IN_JOINTS'((1 << ACTIVE_JOINTS) - 1);

    seq_state_t            state_reg, state_next;
    logic                  active_reg;
    logic [IN_JOINTS-1:0]  mask_reg;
    logic [TIME_BITS-1:0]  length_reg;
    logic [TIME_BITS-1:0]  elapsed_reg;
    logic [JOINT_W-1:0]    idx_reg;
    angle_t                pos_reg  [IN_JOINTS];
    angle_t                goal_reg [IN_JOINTS];

    logic                  out_valid_reg;
    logic                  kind_reg;
    logic [JOINT_W-1:0]    joint_reg;
    angle_t                angle_reg;
    logic                  last_reg;

    angle_t                targets [IN_JOINTS];
    logic                  in_xfer;
    logic                  out_free;
    logic                  ar_start;
    angle_t                ar_quot;
    arith_status_t         ar_status;
    logic                  higher_any;
    logic                  emit_load;
    logic [TIME_BITS-1:0]  new_length;
    logic [TIME_BITS-1:0]  elapsed_inc;
    logic [IN_JOINTS-1:0]  new_mask;

    assign targets[0] = target_0;
    assign targets[1] = target_1;
    assign targets[2] = target_2;
    assign targets[3] = target_3;
    assign targets[4] = target_4;
    assign targets[5] = target_5;

    assign out_free    = !out_valid_reg || out_ready;
    assign in_ready    = (state_reg == ST_IDLE) && out_free;
    assign in_xfer     = in_valid && in_ready;
    assign new_length  = TIME_BITS'(move_time_ms);
    assign new_mask    = joint_mask & ACTIVE_MASK;
    assign elapsed_inc = elapsed_reg + 1'b1;
    assign emit_load   = (state_reg == ST_EMIT) && out_free;

    always_comb
    begin
        higher_any = 1'b0;
        for (int k = 0; k < IN_JOINTS; k++)
        begin
            if (JOINT_W'(k) > idx_reg)
                higher_any = higher_any | mask_reg[k];
        end
    end

    mjli_arith #(
        .TIME_BITS (TIME_BITS)
    ) u_arith (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (ar_start),
        .angle_start (pos_reg[idx_reg]),
        .angle_goal  (goal_reg[idx_reg]),
        .duration    (length_reg),
        .elapsed     (elapsed_reg),
        .quotient    (ar_quot),
        .status      (ar_status)
    );

    always_comb
    begin
        state_next = state_reg;
        ar_start   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && operation == OP_TICK && active_reg)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (mask_reg[idx_reg])
                begin
                    ar_start   = 1'b1;
                    state_next = ST_CALC;
                end
                else if (idx_reg == JOINT_W'(ACTIVE_JOINTS - 1))
                    state_next = ST_STEP;
            end
            ST_CALC:
            begin
                if (ar_status.done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                    state_next = higher_any ? ST_SCAN : ST_STEP;
            end
            ST_STEP:
            begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= 1'b0;
            mask_reg      <= '0;
            length_reg    <= '0;
            elapsed_reg   <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < IN_JOINTS; j++)
                pos_reg[j] <= home_angle(j);
        end
        else
        begin
            state_reg <= state_next;

            if (in_xfer && operation == OP_MOVE && !active_reg)
            begin
                mask_reg    <= new_mask;
                length_reg  <= new_length;
                elapsed_reg <= '0;
                if (new_length == '0)
                begin
                    for (int j = 0; j < ACTIVE_JOINTS; j++)
                        if (new_mask[j])
                            pos_reg[j] <= targets[j];
                end
                else
                    active_reg <= 1'b1;
            end

            if (in_xfer && operation == OP_TICK)
                idx_reg <= '0;
            else if (state_reg == ST_SCAN && !mask_reg[idx_reg]
                     && idx_reg != JOINT_W'(ACTIVE_JOINTS - 1))
                idx_reg <= idx_reg + 1'b1;
            else if (emit_load && higher_any)
                idx_reg <= idx_reg + 1'b1;

            if (state_reg == ST_STEP)
            begin
                elapsed_reg <= elapsed_inc;
                if (elapsed_inc >= length_reg)
                begin
                    active_reg <= 1'b0;
                    for (int j = 0; j < ACTIVE_JOINTS; j++)
                        if (mask_reg[j])
                            pos_reg[j] <= goal_reg[j];
                end
            end

            if ((in_xfer && operation == OP_MOVE && active_reg) || emit_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && operation == OP_MOVE && !active_reg)
        begin
            for (int j = 0; j < ACTIVE_JOINTS; j++)
                goal_reg[j] <= targets[j];
        end

        if (in_xfer && operation == OP_MOVE && active_reg)
        begin
            kind_reg  <= KIND_REJECT;
            joint_reg <= '0;
            angle_reg <= '0;
            last_reg  <= 1'b1;
        end
        else if (emit_load)
        begin
            kind_reg  <= KIND_WRITE;
            joint_reg <= idx_reg;
            angle_reg <= ar_quot;
            last_reg  <= !higher_any;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign joint     = joint_reg;
    assign angle     = angle_reg;
    assign last      = last_reg;

    a_reject_when_active: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && operation == OP_MOVE && active_reg
        |=> out_valid_reg && kind_reg == KIND_REJECT && last_reg)
        else $error("busy command not rejected");

    a_work_only_active: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> active_reg)
        else $error("tick work without a running move");

    a_elapsed_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> elapsed_reg < length_reg)
        else $error("elapsed time reached duration during move");

    a_start_arith_free: assert property (@(posedge clk) disable iff (!rst_n)
        ar_start |-> !ar_status.busy)
        else $error("arith unit started while busy");

endmodule

`default_nettype wire

// File: sim/tb.sv
`default_nettype none

module tb;
    import mjli_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 300;
    localparam int PLAN_ITEMS    = 215;

    typedef angle_t [IN_JOINTS-1:0] target_set_t;

    typedef struct packed {
        logic              op;
        logic [5:0]        mask;
        target_set_t       target;
        logic [DUR_W-1:0]  dur;
        logic              drain;
    } servo_cmd_t;

    typedef struct packed {
        logic               kind;
        logic [JOINT_W-1:0] joint;
        angle_t             angle;
        logic               last;
    } servo_write_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               operation    = 1'b0;
    logic [5:0]         joint_mask   = '0;
    angle_t             target_0     = '0;
    angle_t             target_1     = '0;
    angle_t             target_2     = '0;
    angle_t             target_3     = '0;
    angle_t             target_4     = '0;
    angle_t             target_5     = '0;
    logic [DUR_W-1:0]   move_time_ms = '0;
    logic               out_ready    = 1'b0;
    logic               in_ready;
    logic               out_valid;
    logic               kind;
    logic [JOINT_W-1:0] joint;
    angle_t             angle;
    logic               last;

    // interpolator state mirror
    angle_t           pos_deg [IN_JOINTS] = '{8'd180, 8'd180, 8'd90, 8'd90, 8'd0, 8'd0};
    angle_t           goal_deg [IN_JOINTS] = '{default: '0};
    logic [5:0]       run_mask    = '0;
    logic [DUR_W-1:0] run_len     = '0;
    logic [DUR_W-1:0] run_elapsed = '0;
    logic             run_active  = 1'b0;

    servo_cmd_t   cmd_plan [$];
    servo_write_t due_writes [$];
    servo_cmd_t   cur_cmd;
    int           sent_count  = 0;
    int           fail_count  = 0;
    int           cycle_count = 0;
    logic         calm;

    assign calm = (sent_count >= 110) && (sent_count < 170);

    multi_joint_linear_move_interpolator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .joint_mask   (joint_mask),
        .target_0     (target_0),
        .target_1     (target_1),
        .target_2     (target_2),
        .target_3     (target_3),
        .target_4     (target_4),
        .target_5     (target_5),
        .move_time_ms (move_time_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .joint        (joint),
        .angle        (angle),
        .last         (last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic commit_goals();
        for (int j = 0; j < IN_JOINTS; j++)
        begin
            if (run_mask[j])
                pos_deg[j] = goal_deg[j];
        end
    endtask

    task automatic interpolate_step(input servo_cmd_t c);
        int           last_j;
        int unsigned  num;
        servo_write_t w;
        last_j = -1;
        if (c.op == OP_MOVE)
        begin
            if (run_active)
            begin
                w.kind  = KIND_REJECT;
                w.joint = '0;
                w.angle = '0;
                w.last  = 1'b1;
                due_writes.push_back(w);
            end
            else
            begin
                run_mask = c.mask;
                for (int j = 0; j < IN_JOINTS; j++)
                    goal_deg[j] = c.target[j];
                run_len     = c.dur;
                run_elapsed = '0;
                if (run_len == 0)
                    commit_goals();
                else
                    run_active = 1'b1;
            end
        end
        else if (run_active)
        begin
            for (int j = 0; j < IN_JOINTS; j++)
            begin
                if (run_mask[j])
                    last_j = j;
            end
            for (int j = 0; j < IN_JOINTS; j++)
            begin
                if (run_mask[j])
                begin
                    num = int'(pos_deg[j]) * int'(run_len - run_elapsed)
                        + int'(goal_deg[j]) * int'(run_elapsed);
                    w.kind  = KIND_WRITE;
                    w.joint = JOINT_W'(j);
                    w.angle = angle_t'(num / int'(run_len));
                    w.last  = (j == last_j);
                    due_writes.push_back(w);
                end
            end
            run_elapsed = run_elapsed + 1'b1;
            if (run_elapsed >= run_len)
            begin
                commit_goals();
                run_active = 1'b0;
            end
        end
    endtask

    function automatic target_set_t rand_targets(input bit full_range);
        target_set_t t;
        for (int j = 0; j < IN_JOINTS; j++)
        begin
            if (full_range || $urandom_range(4) == 0)
                t[j] = angle_t'($urandom_range(255));
            else
                t[j] = angle_t'($urandom_range(180));
        end
        return t;
    endfunction

    task automatic push_move(input logic [5:0] m, input target_set_t t,
                             input logic [DUR_W-1:0] d, input logic dr);
        servo_cmd_t c;
        c.op     = OP_MOVE;
        c.mask   = m;
        c.target = t;
        c.dur    = d;
        c.drain  = dr;
        cmd_plan.push_back(c);
    endtask

    task automatic push_tick();
        servo_cmd_t c;
        c.op     = OP_TICK;
        c.mask   = 6'($urandom);
        c.target = rand_targets(1'b1);
        c.dur    = DUR_W'($urandom);
        c.drain  = 1'b0;
        cmd_plan.push_back(c);
    endtask

    task automatic push_noise();
        push_move(6'($urandom), rand_targets(1'b1), DUR_W'($urandom), 1'b0);
    endtask

    // driver
    always @(posedge clk)
    begin
        logic load;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                interpolate_step(cur_cmd);
                sent_count++;
            end
            if (!in_valid || in_ready)
            begin
                load = 1'b0;
                if (cmd_plan.size() != 0)
                begin
                    if (cmd_plan[0].drain && due_writes.size() != 0)
                        load = 1'b0;
                    else if (!calm && $urandom_range(99) < 25)
                        load = 1'b0;
                    else
                        load = 1'b1;
                end
                if (load)
                begin
                    cur_cmd = cmd_plan.pop_front();
                    operation    <= cur_cmd.op;
                    joint_mask   <= cur_cmd.mask;
                    target_0     <= cur_cmd.target[0];
                    target_1     <= cur_cmd.target[1];
                    target_2     <= cur_cmd.target[2];
                    target_3     <= cur_cmd.target[3];
                    target_4     <= cur_cmd.target[4];
                    target_5     <= cur_cmd.target[5];
                    move_time_ms <= cur_cmd.dur;
                end
                in_valid <= load;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        servo_write_t w;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (due_writes.size() == 0)
                begin
                    $error("unexpected transfer: kind=%0d joint=%0d angle=%0d last=%0d",
                           kind, joint, angle, last);
                    fail_count++;
                end
                else
                begin
                    w = due_writes.pop_front();
                    if (kind !== w.kind)
                    begin
                        $error("kind: expected %0d, got %0d", w.kind, kind);
                        fail_count++;
                    end
                    if (joint !== w.joint)
                    begin
                        $error("joint: expected %0d, got %0d", w.joint, joint);
                        fail_count++;
                    end
                    if (angle !== w.angle)
                    begin
                        $error("angle: expected %0d, got %0d", w.angle, angle);
                        fail_count++;
                    end
                    if (last !== w.last)
                    begin
                        $error("last: expected %0d, got %0d", w.last, last);
                        fail_count++;
                    end
                end
            end
            out_ready <= calm || ($urandom_range(99) >= 25);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int               n_ticks;
        int               r;
        logic [DUR_W-1:0] d;
        logic [5:0]       m;

        // tick while idle
        push_tick();
        // full sweep, with a rejected command mid-move
        push_move(6'h3F, {8'd180, 8'd255, 8'd180, 8'd180, 8'd0, 8'd0}, 16'd3, 1'b0);
        push_tick();
        push_move(6'h3F, {6{8'd255}}, 16'hFFFF, 1'b0);
        push_tick();
        push_tick();
        push_tick();
        // zero duration, then a one-tick move
        push_move(6'h15, {8'd7, 8'd180, 8'd0, 8'd255, 8'd45, 8'd1}, 16'd0, 1'b0);
        push_move(6'h3F, rand_targets(1'b0), 16'd1, 1'b0);
        push_tick();
        // empty mask still occupies the duration
        push_move(6'h00, {6{8'd255}}, 16'd2, 1'b0);
        push_tick();
        push_move(6'h00, {6{8'd0}}, 16'd0, 1'b0);
        push_tick();
        // single high joint
        push_move(6'h20, {8'd0, 8'd9, 8'd9, 8'd9, 8'd9, 8'd9}, 16'd2, 1'b0);
        push_tick();
        push_tick();

        while (cmd_plan.size() < PLAN_ITEMS)
        begin
            m = ($urandom_range(9) == 0) ? 6'h00 : 6'($urandom_range(63, 1));
            r = $urandom_range(99);
            if (r < 8)
                d = '0;
            else if (r < 80)
                d = DUR_W'($urandom_range(6, 1));
            else
                d = DUR_W'($urandom_range(16, 7));
            push_move(m, rand_targets(1'b0), d, $urandom_range(19) == 0);
            n_ticks = int'(d);
            if (d > 1 && $urandom_range(19) == 0)
                n_ticks = $urandom_range(n_ticks - 1, 1);
            for (int k = 0; k < n_ticks; k++)
            begin
                push_tick();
                if ($urandom_range(9) == 0)
                    push_noise();
            end
            if ($urandom_range(4) == 0)
                push_tick();
        end

        // longest duration, left running at the end
        push_move(6'h3F, rand_targets(1'b1), '1, 1'b1);
        repeat (3) push_tick();
        push_noise();
        push_tick();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_plan.size() != 0 || in_valid || due_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
